// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared codes, widths and types of the 3x3 median filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mf3_pkg;

    localparam int ROWS_W     = 16;
    localparam int COLS_W     = 11;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // result queue, power of two
    localparam int OUT_DEPTH  = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_ROWS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COLS = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // results caused by one input beat
    typedef struct packed {
        logic first_en;   // first result present
        logic first_med;  // first result is a median, else zero
        logic second_en;  // trailing zero of the right border
        logic frame_end;  // first result closes the frame
    } res_ctl_t;

endpackage

// File: rtl/core/median_filter_3x3.sv
// ----------------------------------------------------------------------------
// median_filter_3x3
// Each input beat's results pass the pipeline stage registers, then the result queue.
// Throughput: one input beat per cycle; the line buffer read/write pair and the
//   compare network are pipelined, and input stalls only while seven or more
//   results are outstanding in the pipeline and the 8-entry result queue.
// Reset: counters, window and queue cleared, frame_rows = frame_cols = 3;
//   line buffers are not cleared (entries are written before they are used).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 16
)(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_we,
    input  logic [CFG_ADDR_W-1:0]                 cfg_addr,
    input  logic [CFG_DATA_W-1:0]                 cfg_wdata,

    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,   // pixel
    input  logic                                  s_axis_tuser,   // cmd

    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,   // value
    output logic                                  m_axis_tlast    // frame_end
);

    localparam int AW    = $clog2(MAX_COLS);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int DW    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] md;
        logic [SAMPLE_BITS-1:0] hi;
    } col_t;

    typedef struct packed {
        logic                   frame_end;
        logic [SAMPLE_BITS-1:0] value;
    } out_item_t;

    function automatic logic [SAMPLE_BITS-1:0] smin(input logic signed [SAMPLE_BITS-1:0] a,
                                                    input logic signed [SAMPLE_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] smax(input logic signed [SAMPLE_BITS-1:0] a,
                                                    input logic signed [SAMPLE_BITS-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] med3(input logic [SAMPLE_BITS-1:0] a,
                                                    input logic [SAMPLE_BITS-1:0] b,
                                                    input logic [SAMPLE_BITS-1:0] c);
        return smax(smin(a, b), smin(smax(a, b), c));
    endfunction

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [ROWS_W-1:0] frame_rows_reg;
    logic [COLS_W-1:0] frame_cols_reg;
    logic [ROWS_W-1:0] rows_eff;
    logic [CW-1:0]     cols_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= ROWS_W'(3);
            frame_cols_reg <= COLS_W'(3);
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_FRAME_ROWS)
            begin
                frame_rows_reg <= cfg_wdata[ROWS_W-1:0];
            end
            if (cfg_addr == REG_FRAME_COLS)
            begin
                frame_cols_reg <= cfg_wdata[COLS_W-1:0];
            end
        end
    end

    always_comb
    begin
        rows_eff = (frame_rows_reg < ROWS_W'(3)) ? ROWS_W'(3) : frame_rows_reg;
        if (frame_cols_reg < COLS_W'(3))
        begin
            cols_eff = CW'(3);
        end
        else if (32'(frame_cols_reg) > 32'(MAX_COLS))
        begin
            cols_eff = CW'(MAX_COLS);
        end
        else
        begin
            cols_eff = CW'(frame_cols_reg);
        end
    end

    // ------------------------------------------------------------------
    // input stage: position counters and result decode
    // ------------------------------------------------------------------
    logic [AW-1:0]     col_pos_reg, col_pos_next;
    logic [ROWS_W-1:0] row_pos_reg, row_pos_next;
    logic [CW-1:0]     drain_pos_reg, drain_pos_next;

    logic [CW-1:0]     col_inc;
    logic [CW-1:0]     drain_inc;
    logic              c_last, c_first, c_ge2, col_ok;
    logic              r_first, r_ge2, rows_ok, drain_last;
    logic              pix_go, drain_go, accept;
    res_ctl_t          ctl_in;
    logic [1:0]        n_in;

    assign col_inc    = CW'(col_pos_reg) + CW'(1);
    assign drain_inc  = drain_pos_reg + CW'(1);
    assign c_last     = (col_inc == cols_eff);
    assign c_first    = (col_pos_reg == '0);
    assign c_ge2      = (col_pos_reg >= AW'(2));
    assign col_ok     = (CW'(col_pos_reg) < cols_eff);
    assign r_first    = (row_pos_reg == '0);
    assign r_ge2      = (row_pos_reg >= ROWS_W'(2));
    assign rows_ok    = (row_pos_reg < rows_eff);
    assign drain_last = (drain_inc >= cols_eff);

    always_comb
    begin
        ctl_in   = '0;
        pix_go   = 1'b0;
        drain_go = 1'b0;
        if (s_axis_tuser == CMD_DRAIN)
        begin
            // drain counts only once every row is in
            if (!rows_ok)
            begin
                drain_go         = 1'b1;
                ctl_in.first_en  = 1'b1;
                ctl_in.frame_end = drain_last;
            end
        end
        else if (rows_ok && col_ok)
        begin
            pix_go           = 1'b1;
            ctl_in.first_en  = r_first | (r_ge2 & (c_first | c_ge2));
            ctl_in.first_med = r_ge2 & c_ge2;
            ctl_in.second_en = r_ge2 & c_last;
        end
    end

    assign n_in   = {1'b0, ctl_in.first_en} + {1'b0, ctl_in.second_en};
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        col_pos_next   = col_pos_reg;
        row_pos_next   = row_pos_reg;
        drain_pos_next = drain_pos_reg;
        if (cfg_we)
        begin
            col_pos_next   = '0;
            row_pos_next   = '0;
            drain_pos_next = '0;
        end
        else if (accept && drain_go)
        begin
            if (drain_last)
            begin
                col_pos_next   = '0;
                row_pos_next   = '0;
                drain_pos_next = '0;
            end
            else
            begin
                drain_pos_next = drain_inc;
            end
        end
        else if (accept && pix_go)
        begin
            if (c_last)
            begin
                col_pos_next = '0;
                row_pos_next = row_pos_reg + ROWS_W'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: line buffer data back, write-back, column sort
    // ------------------------------------------------------------------
    logic                   s1_pix_reg;
    res_ctl_t               s1_ctl_reg;
    logic [AW-1:0]          s1_addr_reg;
    logic [SAMPLE_BITS-1:0] s1_px_reg;
    logic [SAMPLE_BITS-1:0] two_rdata, above_rdata;
    logic [SAMPLE_BITS-1:0] x_lo, x_hi, y_lo;
    col_t                   new_col;
    col_t                   win_reg [2];

    // both buffers are read at the current column on every cycle; the beat
    // accepted now sees its data in stage 1, where the column is written back
    mf3_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_COLS)
    ) u_line_two_above (
        .clk   (clk),
        .we    (s1_pix_reg),
        .waddr (s1_addr_reg),
        .wdata (above_rdata),
        .raddr (col_pos_reg),
        .rdata (two_rdata)
    );

    mf3_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_COLS)
    ) u_line_above (
        .clk   (clk),
        .we    (s1_pix_reg),
        .waddr (s1_addr_reg),
        .wdata (s1_px_reg),
        .raddr (col_pos_reg),
        .rdata (above_rdata)
    );

    // three-element sort of the new column
    always_comb
    begin
        x_lo       = smin(two_rdata, above_rdata);
        x_hi       = smax(two_rdata, above_rdata);
        y_lo       = smin(x_hi, s1_px_reg);
        new_col.hi = smax(x_hi, s1_px_reg);
        new_col.lo = smin(x_lo, y_lo);
        new_col.md = smax(x_lo, y_lo);
    end

    // ------------------------------------------------------------------
    // stages 2 and 3: max of lows, median of middles, min of highs, median
    // ------------------------------------------------------------------
    res_ctl_t               s2_ctl_reg;
    col_t                   s2_col_reg [3];
    res_ctl_t               s3_ctl_reg;
    logic [SAMPLE_BITS-1:0] s3_lo_reg, s3_md_reg, s3_hi_reg;
    logic [SAMPLE_BITS-1:0] lo_max, md_med, hi_min, med;

    always_comb
    begin
        lo_max = smax(smax(s2_col_reg[0].lo, s2_col_reg[1].lo), s2_col_reg[2].lo);
        md_med = med3(s2_col_reg[0].md, s2_col_reg[1].md, s2_col_reg[2].md);
        hi_min = smin(smin(s2_col_reg[0].hi, s2_col_reg[1].hi), s2_col_reg[2].hi);
        med    = med3(s3_lo_reg, s3_md_reg, s3_hi_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_pix_reg <= 1'b0;
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            win_reg[0] <= '0;
            win_reg[1] <= '0;
        end
        else
        begin
            s1_pix_reg <= accept && pix_go;
            s1_ctl_reg <= accept ? ctl_in : '0;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            if (s1_pix_reg)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= new_col;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg   <= col_pos_reg;
        s1_px_reg     <= s_axis_tdata[SAMPLE_BITS-1:0];
        s2_col_reg[0] <= win_reg[0];
        s2_col_reg[1] <= win_reg[1];
        s2_col_reg[2] <= new_col;
        s3_lo_reg     <= lo_max;
        s3_md_reg     <= md_med;
        s3_hi_reg     <= hi_min;
    end

    // ------------------------------------------------------------------
    // result queue; space is reserved when a beat is accepted
    // ------------------------------------------------------------------
    out_item_t        fifo_reg [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0] n_push, n_add;
    logic             pop;
    out_item_t        item0, head;

    assign n_push = CNT_W'(s3_ctl_reg.first_en) + CNT_W'(s3_ctl_reg.second_en);
    assign n_add  = accept ? CNT_W'(n_in) : '0;
    assign pop    = m_axis_tvalid && m_axis_tready;

    assign item0.value     = s3_ctl_reg.first_med ? med : '0;
    assign item0.frame_end = s3_ctl_reg.frame_end;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + n_push - CNT_W'(pop);
        pend_next   = pend_reg + n_add - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            drain_pos_reg <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            drain_pos_reg <= drain_pos_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ctl_reg.first_en)
        begin
            fifo_reg[wr_ptr_reg] <= item0;
        end
        if (s3_ctl_reg.second_en)
        begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= '0;
        end
    end

    assign head          = fifo_reg[rd_ptr_reg];
    assign s_axis_tready = (pend_reg <= CNT_W'(OUT_DEPTH - 2));
    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = DW'(head.value);
    assign m_axis_tlast  = head.frame_end;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_queue_in_pend, cnt_reg <= pend_reg, "queue holds more than reserved")
    `ASSERT_ALWAYS(a_pend_bound, pend_reg <= CNT_W'(OUT_DEPTH), "reservation overflow")
    `ASSERT_IMPLY(a_stall_has_out, !s_axis_tready, m_axis_tvalid, "stalled with empty queue")
    `ASSERT_IMPLY(a_end_is_zero, m_axis_tvalid && m_axis_tlast, m_axis_tdata == '0,
                  "frame end beat carries a nonzero value")

endmodule

// File: rtl/core/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
